### rtl/core/lef_pkg.sv
// ----------------------------------------------------------------------------
// lef_pkg
// Shared widths, limits and types of the 3x3 Laplacian edge filter.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned SIZE_MIN   = 3;
  localparam int unsigned SIZE_RESET = 512;
  // kernel sum, signed, wide enough for +-8*255
  localparam int unsigned SUM_W      = PIX_W + 4;

  // position flags of one accepted pixel
  typedef struct packed {
    logic produce;
    logic row_end;
    logic frame_end;
  } pos_t;

endpackage

### rtl/core/lef_if.sv
// ----------------------------------------------------------------------------
// lef_if
// Valid/ready channels of the edge filter: pixels in, results out, config.
// ----------------------------------------------------------------------------
interface lef_pix_if;
  logic                      valid;
  logic                      ready;
  logic [lef_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface lef_res_if;
  logic                      valid;
  logic                      ready;
  logic [lef_pkg::PIX_W-1:0] edge_value;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, output edge_value, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input edge_value, input row_end, input frame_end,
                  output ready);
endinterface

interface lef_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lef_pkg::SIZE_W-1:0] side_len;

  modport source (output valid, output side_len, input ready);
  modport sink   (input valid, input side_len, output ready);
endinterface

### rtl/core/laplacian_edge_filter_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_edge_filter_3x3
// Streaming 3x3 Laplacian edge filter for square 8-bit images.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_i  takes one pixel beat per cycle in raster order.
//   result_o gives one beat per interior pixel: clamped 8*centre minus the
//            eight neighbours, with row_end and frame_end marks. Border rows
//            and columns give no beat.
//   cfg_i    writes the image side length (clamped to 3..1024); it restarts
//            the frame position at the next pixel. Write only while idle.
// Pipeline: the pixel beat that completes a window is registered with its
//   line store reads in stage one, then its result in the result register.
//   Throughput: one pixel per cycle unless result_o stalls, set by the single
//   read and write port of each line store RAM and the one-stage kernel.
// Reset: clears the position counters and sets the side length to 512; the
//   line stores are not cleared, nor need they be.
// Stall: the result register holds while result_o.ready is low, the RAM read
//   stage fills behind it, and pixel_i.ready then drops.
// ----------------------------------------------------------------------------
module laplacian_edge_filter_3x3 (
  input  logic      clk_i,
  input  logic      rst_ni,
  lef_pix_if.sink   pixel_i,
  lef_res_if.source result_o,
  lef_cfg_if.sink   cfg_i
);

  logic                      accept;
  logic                      cfg_we;
  logic [lef_pkg::COL_W-1:0] col;
  lef_pkg::pos_t             pos;
  logic                      st_we;
  logic [lef_pkg::COL_W-1:0] st_addr;
  logic [lef_pkg::PIX_W-1:0] up_wd;
  logic [lef_pkg::PIX_W-1:0] mid_wd;
  logic [lef_pkg::PIX_W-1:0] up_rd;
  logic [lef_pkg::PIX_W-1:0] mid_rd;

  assign accept      = pixel_i.valid && pixel_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  lef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_size_i (cfg_i.side_len),
    .accept_i   (accept),
    .col_o      (col),
    .pos_o      (pos)
  );

  lef_ram #(
    .WIDTH (lef_pkg::PIX_W),
    .DEPTH (lef_pkg::MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_addr),
    .wdata_i (up_wd),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (up_rd)
  );

  lef_ram #(
    .WIDTH (lef_pkg::PIX_W),
    .DEPTH (lef_pkg::MAX_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_addr),
    .wdata_i (mid_wd),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (mid_rd)
  );

  lef_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pixel_i      (pixel_i.pixel_in),
    .col_i        (col),
    .pos_i        (pos),
    .ready_o      (pixel_i.ready),
    .up_rd_i      (up_rd),
    .mid_rd_i     (mid_rd),
    .st_we_o      (st_we),
    .st_addr_o    (st_addr),
    .up_wd_o      (up_wd),
    .mid_wd_o     (mid_wd),
    .res_valid_o  (result_o.valid),
    .res_ready_i  (result_o.ready),
    .edge_value_o (result_o.edge_value),
    .row_end_o    (result_o.row_end),
    .frame_end_o  (result_o.frame_end)
  );

endmodule

### rtl/core/lef_ram.sv
// ----------------------------------------------------------------------------
// lef_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lef_ctrl.sv
// ----------------------------------------------------------------------------
// lef_ctrl
// Image size register and raster position counters.
// ----------------------------------------------------------------------------
module lef_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lef_pkg::SIZE_W-1:0] cfg_size_i,
  input  logic                      accept_i,
  output logic [lef_pkg::COL_W-1:0] col_o,
  output lef_pkg::pos_t             pos_o
);

  logic [lef_pkg::COL_W-1:0] last_q, last_d;
  logic [lef_pkg::COL_W-1:0] col_q, col_d;
  logic [lef_pkg::COL_W-1:0] row_q, row_d;
  logic                      last_col;
  logic                      last_row;

  // last index = size clamped to the supported range, minus one
  always_comb begin
    if (cfg_size_i < lef_pkg::SIZE_W'(lef_pkg::SIZE_MIN)) begin
      last_d = lef_pkg::COL_W'(lef_pkg::SIZE_MIN - 1);
    end else if (cfg_size_i > lef_pkg::SIZE_W'(lef_pkg::MAX_WIDTH)) begin
      last_d = lef_pkg::COL_W'(lef_pkg::MAX_WIDTH - 1);
    end else begin
      last_d = lef_pkg::COL_W'(cfg_size_i - 1'b1);
    end
  end

  assign last_col = (col_q == last_q);
  assign last_row = (row_q == last_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= lef_pkg::COL_W'(lef_pkg::SIZE_RESET - 1);
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        last_q <= last_d;
      end
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o           = col_q;
  assign pos_o.produce   = (row_q >= lef_pkg::COL_W'(2)) && (col_q >= lef_pkg::COL_W'(2));
  assign pos_o.row_end   = last_col;
  assign pos_o.frame_end = last_col && last_row;

endmodule

### rtl/core/lef_core.sv
// ----------------------------------------------------------------------------
// lef_core
// Line store write-back, 3x3 window, Laplacian kernel and result register.
// ----------------------------------------------------------------------------
module lef_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [lef_pkg::PIX_W-1:0] pixel_i,
  input  logic [lef_pkg::COL_W-1:0] col_i,
  input  lef_pkg::pos_t             pos_i,
  output logic                      ready_o,
  input  logic [lef_pkg::PIX_W-1:0] up_rd_i,
  input  logic [lef_pkg::PIX_W-1:0] mid_rd_i,
  output logic                      st_we_o,
  output logic [lef_pkg::COL_W-1:0] st_addr_o,
  output logic [lef_pkg::PIX_W-1:0] up_wd_o,
  output logic [lef_pkg::PIX_W-1:0] mid_wd_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [lef_pkg::PIX_W-1:0] edge_value_o,
  output logic                      row_end_o,
  output logic                      frame_end_o
);

  logic                      s1_valid_q;
  logic [lef_pkg::PIX_W-1:0] s1_pix_q;
  logic [lef_pkg::COL_W-1:0] s1_col_q;
  lef_pkg::pos_t             s1_pos_q;
  logic                      s1_adv;

  // window columns: [row][0] older, [row][1] newer
  logic [lef_pkg::PIX_W-1:0] win_q [3][2];
  logic [lef_pkg::PIX_W-1:0] new_col [3];

  logic                      out_valid_q;
  logic [lef_pkg::PIX_W-1:0] out_edge_q, out_edge_d;
  logic                      out_row_end_q;
  logic                      out_frame_end_q;

  logic signed [lef_pkg::SUM_W-1:0] centre8;
  logic signed [lef_pkg::SUM_W-1:0] nsum;
  logic signed [lef_pkg::SUM_W-1:0] diff;

  assign s1_adv  = !out_valid_q || res_ready_i;
  assign ready_o = !s1_valid_q || s1_adv;

  assign new_col[0] = up_rd_i;
  assign new_col[1] = mid_rd_i;
  assign new_col[2] = s1_pix_q;

  // row above moves into the upper store, the new pixel into the middle one
  assign st_we_o   = s1_valid_q && s1_adv;
  assign st_addr_o = s1_col_q;
  assign up_wd_o   = mid_rd_i;
  assign mid_wd_o  = s1_pix_q;

  // kernel over the shifted window: centre is the previous newest middle pixel
  always_comb begin
    centre8 = lef_pkg::SUM_W'({win_q[1][1], 3'b000});
    nsum    = lef_pkg::SUM_W'(win_q[0][0]) + lef_pkg::SUM_W'(win_q[0][1])
            + lef_pkg::SUM_W'(new_col[0])
            + lef_pkg::SUM_W'(win_q[1][0]) + lef_pkg::SUM_W'(new_col[1])
            + lef_pkg::SUM_W'(win_q[2][0]) + lef_pkg::SUM_W'(win_q[2][1])
            + lef_pkg::SUM_W'(new_col[2]);
    diff    = centre8 - nsum;
    if (diff < 0) begin
      out_edge_d = '0;
    end else if (diff > lef_pkg::SUM_W'(255)) begin
      out_edge_d = '1;
    end else begin
      out_edge_d = diff[lef_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s1_valid_q <= accept_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && s1_pos_q.produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pix_q <= pixel_i;
      s1_col_q <= col_i;
      s1_pos_q <= pos_i;
    end
    if (s1_valid_q && s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= new_col[r];
      end
      out_edge_q      <= out_edge_d;
      out_row_end_q   <= s1_pos_q.row_end;
      out_frame_end_q <= s1_pos_q.frame_end;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign edge_value_o = out_edge_q;
  assign row_end_o    = out_row_end_q;
  assign frame_end_o  = out_frame_end_q;

endmodule

### rtl/core/lef_checker.sv
// ----------------------------------------------------------------------------
// lef_checker
// Port-level assertions on the edge filter, bound to the top level.
// ----------------------------------------------------------------------------
module lef_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [lef_pkg::PIX_W-1:0] edge_value_i,
  input logic                      row_end_i,
  input logic                      frame_end_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable(edge_value_i) && $stable(row_end_i) && $stable(frame_end_i))
    else $error("result payload changed while stalled");

  // last result of the frame is also the last of its row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && frame_end_i |-> row_end_i)
    else $error("frame_end without row_end");

  // an empty result register fills only from a pixel beat that went through the stage-one register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(in_beat, 2))
    else $error("result appeared without a pixel beat two cycles back");

endmodule

bind laplacian_edge_filter_3x3 lef_checker u_lef_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pixel_i.valid),
  .in_ready_i   (pixel_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .edge_value_i (result_o.edge_value),
  .row_end_i    (result_o.row_end),
  .frame_end_i  (result_o.frame_end)
);

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 3x3 Laplacian edge filter. A
// behavioral predictor keeps its own line stores, window and frame position,
// computes the expected edge beat for each completed interior window, and a monitor
// compares each result beat field by field in order. Runs reset size, corner
// kernels, random frames of many sizes, a long result stall and an oversized
// side length, with random sender gaps and receiver stalls in most tests.
// ----------------------------------------------------------------------------
module testbench;
  import lef_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             row_end;
    logic             frame_end;
  } edge_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;
  typedef enum logic [1:0] {PIX_UNIFORM, PIX_EXTREME, PIX_FLAT} pix_style_e;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 380;

  logic clk;
  logic rst_n;

  lef_pix_if pix_if ();
  lef_res_if res_if ();
  lef_cfg_if cfg_if ();

  laplacian_edge_filter_3x3 uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .pixel_i  (pix_if.sink),
    .result_o (res_if.source),
    .cfg_i    (cfg_if.sink)
  );

  // predictor state
  logic [PIX_W-1:0]  upper_row  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_row [MAX_WIDTH];
  logic [PIX_W-1:0]  win        [9];
  int unsigned       frame_col;
  int unsigned       frame_row;
  logic [SIZE_W-1:0] frame_size;
  edge_result_t      expected_edges [$];

  int         errors;
  int         burst_left;
  bit         steady_sender;
  rx_mode_e   rx_mode;
  bit         hold_req;
  int         hold_left;
  int         rx_phase;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v);
    if (v < SIZE_MIN) return SIZE_MIN;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return 32'(v);
  endfunction

  // one pixel beat into the predictor; queues the edge result it completes
  function automatic void predict_edge(input logic [PIX_W-1:0] p);
    int unsigned      n;
    int unsigned      c;
    int unsigned      r;
    int               acc;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    edge_result_t     res;
    n = clamp_size(frame_size);
    c = (frame_col >= n) ? 0 : frame_col;
    r = (frame_row >= n) ? 0 : frame_row;
    up = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = p;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = p;
    if (r >= 2 && c >= 2) begin
      acc = 8 * int'(win[4]);
      for (int k = 0; k < 9; k++) begin
        if (k != 4) acc -= int'(win[k]);
      end
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      res.edge_value = acc[PIX_W-1:0];
      res.row_end    = (c == n - 1);
      res.frame_end  = (c == n - 1) && (r == n - 1);
      expected_edges.push_back(res);
    end
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    frame_col = c;
    frame_row = r;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel(input pix_style_e style);
    case (style)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      PIX_FLAT:    return PIX_W'($urandom_range(120, 136));
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk);
          pix_if.valid <= 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= p;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    predict_edge(p);
  endtask

  // stop sending and let every expected beat and any border pixel drain
  task automatic drain();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_side_len(input logic [SIZE_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_if.valid    <= 1'b1;
    cfg_if.side_len <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    frame_size = v;
    frame_col  = 0;
    frame_row  = 0;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_kernel(input logic [PIX_W-1:0] centre, input logic [PIX_W-1:0] around);
    for (int k = 0; k < 9; k++) send_pixel((k == 4) ? centre : around);
  endtask

  // size after reset is 512: the start of the first row gives no beat
  task automatic test_reset_size();
    rx_mode = RX_RANDOM;
    repeat (32) send_pixel(random_pixel(PIX_UNIFORM));
  endtask

  task automatic test_corner_kernels();
    rx_mode = RX_ALWAYS;
    write_side_len(SIZE_W'(SIZE_MIN));
    send_kernel(8'hff, 8'h00);  // clamps high
    send_kernel(8'h00, 8'hff);  // clamps low
    // below-minimum size falls back to 3x3
    write_side_len('0);
    send_kernel(8'd128, 8'd127);
  endtask

  task automatic test_random_frames();
    int                sent;
    int                count;
    int unsigned       n;
    logic [SIZE_W-1:0] size_sel;
    pix_style_e        style;
    sent = 0;
    while (sent < int'(RANDOM_ITEMS)) begin
      case ($urandom_range(0, 9))
        0:       size_sel = SIZE_W'($urandom_range(0, 2));
        1:       size_sel = SIZE_W'($urandom_range(13, 20));
        default: size_sel = SIZE_W'($urandom_range(3, 12));
      endcase
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      steady_sender = ($urandom_range(0, 3) == 0);
      write_side_len(size_sel);
      n = clamp_size(size_sel);
      // whole frames cross the wrap; a trailing partial frame ends mid-image
      count = n * n * $urandom_range(1, 2);
      if ($urandom_range(0, 1)) count += $urandom_range(0, n * n - 1);
      if (count > int'(RANDOM_ITEMS) - sent) count = int'(RANDOM_ITEMS) - sent;
      repeat (count) begin
        style = pix_style_e'($urandom_range(0, 2));
        send_pixel(random_pixel(style));
      end
      sent += count;
    end
    steady_sender = 1'b0;
  endtask

  // result side blocks for a long stretch while pixels keep coming
  task automatic test_result_stall();
    rx_mode = RX_ALWAYS;
    write_side_len(SIZE_W'(8));
    steady_sender = 1'b1;
    hold_req = 1'b1;
    repeat (96) send_pixel(random_pixel(PIX_UNIFORM));
    steady_sender = 1'b0;
  endtask

  // oversized value clamps to the largest width: no beat within the first row
  task automatic test_max_width();
    rx_mode = RX_RANDOM;
    write_side_len({SIZE_W{1'b1}});
    repeat (24) send_pixel(random_pixel(PIX_EXTREME));
  endtask

  // receiver stall pattern, with a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:  res_if.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: res_if.ready <= ((rx_phase % 7) >= 3);
        default:    res_if.ready <= 1'b1;
      endcase
    end
    rx_phase++;
  end

  always @(posedge clk) begin
    edge_result_t exp_beat;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %0d/%0b/%0b", $time,
                 res_if.edge_value, res_if.row_end, res_if.frame_end);
        errors++;
      end else begin
        exp_beat = expected_edges.pop_front();
        if (res_if.edge_value !== exp_beat.edge_value) begin
          $display("%0t: edge_value mismatch: expected %0d, actual %0d", $time,
                   exp_beat.edge_value, res_if.edge_value);
          errors++;
        end
        if (res_if.row_end !== exp_beat.row_end) begin
          $display("%0t: row_end mismatch: expected %0b, actual %0b", $time,
                   exp_beat.row_end, res_if.row_end);
          errors++;
        end
        if (res_if.frame_end !== exp_beat.frame_end) begin
          $display("%0t: frame_end mismatch: expected %0b, actual %0b", $time,
                   exp_beat.frame_end, res_if.frame_end);
          errors++;
        end
      end
    end
  end

  initial begin
    errors          = 0;
    burst_left      = 0;
    steady_sender   = 1'b0;
    rx_mode         = RX_ALWAYS;
    hold_req        = 1'b0;
    hold_left       = 0;
    rx_phase        = 0;
    frame_size      = SIZE_W'(SIZE_RESET);
    frame_col       = 0;
    frame_row       = 0;
    pix_if.valid    = 1'b0;
    pix_if.pixel_in = '0;
    res_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.side_len = '0;
    rst_n           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_size();
    test_corner_kernels();
    test_random_frames();
    test_result_stall();
    test_max_width();

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
